// ----- rtl/stpr_pkg.sv -----
// shared types, constants and helpers for the four-wire stepper sequencer
package stpr_pkg;

   localparam int COUNT_BITS = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int INTERVAL_BITS = 16;

   localparam logic [15:0] MS_PER_MIN = 16'd60000;
   localparam logic [15:0] RESET_STEPS_PER_REV = 16'd200;
   localparam logic [15:0] RESET_SPEED_RPM = 16'd60;
   localparam logic [INTERVAL_BITS-1:0] RESET_INTERVAL = 16'd5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEPS_PER_REV = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_RPM = 2'd1;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_MOVE = 1'b1
   } command_type;

   typedef struct packed {
      logic                         command;
      logic signed [COUNT_BITS-1:0] step_count;
   } req_type;

   typedef struct packed {
      logic [3:0]  coil_pattern;
      logic        stepped;
      logic        busy_res;
      logic [15:0] position;
      logic        moving_forward;
   } rsp_type;

   typedef struct packed {
      logic                     busy;
      logic [INTERVAL_BITS-1:0] interval;
   } intv_stat_type;

   function automatic logic [3:0] phase_bits(input logic [1:0] phase);
      logic [3:0] bits;
      case (phase)
         2'd0: bits = 4'd5;
         2'd1: bits = 4'd6;
         2'd2: bits = 4'd10;
         2'd3: bits = 4'd9;
         default: bits = 4'd0;
      endcase
      return bits;
   endfunction

endpackage

// ----- rtl/stpr_interval_div.sv -----
// step interval unit: 60000 / (steps_per_rev * speed_rpm), one quotient bit per cycle
module stpr_interval_div
   import stpr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [15:0]   steps_per_rev,
   input  logic [15:0]   speed_rpm,
   output intv_stat_type stat
);

   logic                     busy_ff, busy_in;
   logic [3:0]               cnt_ff, cnt_in;
   logic [15:0]              rem_ff, rem_in;
   logic [15:0]              quo_ff, quo_in;
   logic [31:0]              dvs_ff, dvs_in;
   logic [INTERVAL_BITS-1:0] intv_ff, intv_in;

   logic [15:0] rev_eff;
   logic [15:0] rpm_eff;
   logic [16:0] trial;
   logic        fits;

   assign rev_eff = (steps_per_rev == 16'd0) ? 16'd1 : steps_per_rev;
   assign rpm_eff = (speed_rpm == 16'd0) ? 16'd1 : speed_rpm;
   assign trial = {rem_ff, MS_PER_MIN[4'd15 - cnt_ff]};
   assign fits = {15'd0, trial} >= dvs_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      intv_in = intv_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = 4'd0;
         rem_in = 16'd0;
         quo_in = 16'd0;
         dvs_in = rev_eff * rpm_eff;
      end else if (busy_ff) begin
         rem_in = fits ? 16'(trial - dvs_ff[16:0]) : trial[15:0];
         quo_in = {quo_ff[14:0], fits};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            intv_in = {quo_ff[14:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= 4'd0;
         intv_ff <= RESET_INTERVAL;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
         intv_ff <= intv_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.interval = intv_ff;

endmodule

// ----- rtl/stpr_step_core.sv -----
// motion state and per-item step decision, result written to the output register
module stpr_step_core
   import stpr_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  req_type                  req_item,
   input  logic [INTERVAL_BITS-1:0] interval,
   input  logic [15:0]              steps_per_rev,
   output rsp_type                  rsp_item
);

   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic [TIME_BITS-1:0]  last_ff, last_in;
   logic [15:0]           pos_ff, pos_in;
   logic                  dir_ff, dir_in;
   logic [COUNT_BITS-1:0] left_ff, left_in;
   logic [3:0]            coil_ff, coil_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  neg;
   logic [COUNT_BITS-1:0] count_raw;
   logic [COUNT_BITS-1:0] mag;
   logic [COUNT_BITS-1:0] left_mid;
   logic [TIME_BITS-1:0]  elapsed;
   logic                  do_step;
   logic [15:0]           rev_eff;
   logic [16:0]           pos_inc;
   logic [15:0]           pos_step;

   assign count_raw = req_item.step_count;
   assign neg = count_raw[COUNT_BITS-1];
   assign mag = neg ? (~count_raw + 1'b1) : count_raw;
   assign rev_eff = (steps_per_rev == 16'd0) ? 16'd1 : steps_per_rev;
   assign pos_inc = {1'b0, pos_ff} + 17'd1;

   always_comb begin
      time_in = time_ff;
      dir_in = dir_ff;
      left_mid = left_ff;
      if (req_item.command == CMD_MOVE) begin
         left_mid = mag;
         if (count_raw != '0) begin
            dir_in = ~neg;
         end
      end else begin
         time_in = time_ff + 1'b1;
      end
      elapsed = time_in - last_ff;
      do_step = (left_mid != '0) && (elapsed >= TIME_BITS'(interval));

      if (dir_in) begin
         pos_step = (pos_inc >= {1'b0, rev_eff}) ? 16'd0 : pos_inc[15:0];
      end else begin
         pos_step = ((pos_ff == 16'd0) || (pos_ff >= rev_eff)) ? (rev_eff - 16'd1)
                                                                : (pos_ff - 16'd1);
      end

      last_in = last_ff;
      pos_in = pos_ff;
      coil_in = coil_ff;
      left_in = left_mid;
      if (do_step) begin
         last_in = time_in;
         pos_in = pos_step;
         coil_in = phase_bits(pos_step[1:0]);
         left_in = left_mid - 1'b1;
      end

      rsp_in.coil_pattern = coil_in;
      rsp_in.stepped = do_step;
      rsp_in.busy_res = (left_in != '0);
      rsp_in.position = pos_in;
      rsp_in.moving_forward = dir_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         last_ff <= '0;
         pos_ff <= 16'd0;
         dir_ff <= 1'b0;
         left_ff <= '0;
         coil_ff <= 4'd0;
      end else if (accept) begin
         time_ff <= time_in;
         last_ff <= last_in;
         pos_ff <= pos_in;
         dir_ff <= dir_in;
         left_ff <= left_in;
         coil_ff <= coil_in;
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

// ----- rtl/four_wire_stepper_sequencer_unit.sv -----
// top level: four-wire full-step stepper sequencer with csr port and item channels
// the result of an accepted item is in the output register in the next cycle
// throughput: one item per cycle unless stalled, taken in the cycle the last one leaves
// csr writes block items, settings writes also while the divider works a bit per cycle
// synchronous active-high reset: coils off, position 0, direction backward, interval 5
module four_wire_stepper_sequencer_unit
   import stpr_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_payload,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [15:0]   rev_ff, rev_in;
   logic [15:0]   rpm_ff, rpm_in;
   logic          start_ff, start_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   intv_stat_type div_stat;

   always_comb begin
      rev_in = rev_ff;
      rpm_in = rpm_ff;
      start_in = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_STEPS_PER_REV: begin
               rev_in = csr_wdata;
               start_in = 1'b1;
            end
            CSR_SPEED_RPM: begin
               rpm_in = csr_wdata;
               start_in = 1'b1;
            end
            default: begin
               start_in = 1'b0;
            end
         endcase
      end
   end

   assign req_ready = !csr_we && !start_ff && !div_stat.busy && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_ff <= RESET_STEPS_PER_REV;
         rpm_ff <= RESET_SPEED_RPM;
         start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rev_ff <= rev_in;
         rpm_ff <= rpm_in;
         start_ff <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   stpr_interval_div u_div (
      .clock         (clock),
      .reset         (reset),
      .start         (start_ff),
      .steps_per_rev (rev_ff),
      .speed_rpm     (rpm_ff),
      .stat          (div_stat)
   );

   stpr_step_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_item      (req_payload),
      .interval      (div_stat.interval),
      .steps_per_rev (rev_ff),
      .rsp_item      (rsp_payload)
   );

   assign rsp_valid = rsp_valid_ff;

   a_no_item_while_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> !accept)
      else $error("item accepted while interval unit busy");

   a_item_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item produced no result");

   a_csr_blocks_items: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index == CSR_STEPS_PER_REV || csr_index == CSR_SPEED_RPM))
      |=> !req_ready)
      else $error("items taken right after a csr write");

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the four-wire stepper sequencer with a scoreboard and random items
`timescale 1ns / 100ps

module tb_top;
   import stpr_pkg::*;

   localparam int TIME_BITS = 32;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 120;
   localparam int RANDOM_PHASES = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   class stepper_scoreboard;
      logic [15:0]           rev_reg;
      logic [15:0]           rpm_reg;
      logic [15:0]           interval;
      logic [TIME_BITS-1:0]  ms_count;
      logic [TIME_BITS-1:0]  last_step_ms;
      logic [15:0]           position;
      logic                  forward;
      logic [COUNT_BITS-1:0] remaining;
      logic [3:0]            coils;
      logic [3:0]            coil_phase [4];
      rsp_type               pending [$];
      int                    errors;

      function new();
         coil_phase = '{4'd5, 4'd6, 4'd10, 4'd9};
         rev_reg = RESET_STEPS_PER_REV;
         rpm_reg = RESET_SPEED_RPM;
         ms_count = '0;
         last_step_ms = '0;
         position = '0;
         forward = 1'b0;
         remaining = '0;
         coils = '0;
         errors = 0;
         refresh_interval();
      endfunction

      function int nonzero(logic [15:0] value);
         return (value == 16'd0) ? 1 : int'(value);
      endfunction

      function void refresh_interval();
         interval = 16'(60000 / nonzero(rev_reg) / nonzero(rpm_reg));
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [15:0] value);
         if (index == CSR_STEPS_PER_REV) begin
            rev_reg = value;
         end else if (index == CSR_SPEED_RPM) begin
            rpm_reg = value;
         end else begin
            return;
         end
         refresh_interval();
      endfunction

      function void note_item(req_type item);
         rsp_type              want;
         logic [TIME_BITS-1:0] elapsed;
         logic                 stepped_now;
         int                   rev;
         stepped_now = 1'b0;
         rev = nonzero(rev_reg);
         if (item.command == CMD_MOVE) begin
            if (item.step_count != '0) begin
               forward = ~item.step_count[COUNT_BITS-1];
            end
            remaining = item.step_count[COUNT_BITS-1] ? (~item.step_count + 1'b1)
                                                      : item.step_count;
         end else begin
            ms_count = ms_count + 1'b1;
         end
         elapsed = ms_count - last_step_ms;
         if (remaining != '0 && elapsed >= {16'd0, interval}) begin
            last_step_ms = ms_count;
            if (forward) begin
               position = (int'(position) + 1 >= rev) ? 16'd0 : position + 16'd1;
            end else begin
               position = (position == 16'd0 || position >= rev) ? 16'(rev - 1)
                                                                 : position - 16'd1;
            end
            coils = coil_phase[position[1:0]];
            remaining = remaining - 1'b1;
            stepped_now = 1'b1;
         end
         want.coil_pattern = coils;
         want.stepped = stepped_now;
         want.busy_res = (remaining != '0);
         want.position = position;
         want.moving_forward = forward;
         pending.push_back(want);
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("coil_pattern", want.coil_pattern, got.coil_pattern);
         compare_field("stepped", want.stepped, got.stepped);
         compare_field("busy_res", want.busy_res, got.busy_res);
         compare_field("position", want.position, got.position);
         compare_field("moving_forward", want.moving_forward, got.moving_forward);
      endfunction

      function bit drained();
         return pending.size() == 0;
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_payload;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   stepper_scoreboard sb;
   bit calm = 1'b0;
   bit hold_req = 1'b0;
   int hold_left = 0;
   int stall_cycles = 0;

   four_wire_stepper_sequencer_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 6);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_rsp(rsp_payload);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_type make_item(logic command, logic signed [COUNT_BITS-1:0] count);
      req_type item;
      item.command = command;
      item.step_count = count;
      return item;
   endfunction

   function automatic req_type random_item();
      req_type item;
      int      pick;
      item.step_count = COUNT_BITS'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         item.command = CMD_TICK;
      end else begin
         item.command = CMD_MOVE;
         if (pick < 90) begin
            item.step_count = COUNT_BITS'(int'($urandom_range(0, 40)) - 20);
         end else if (pick < 96) begin
            case ($urandom_range(0, 2))
               0: item.step_count = {1'b1, {(COUNT_BITS-1){1'b0}}};
               1: item.step_count = {1'b0, {(COUNT_BITS-1){1'b1}}};
               default: item.step_count = '0;
            endcase
         end
      end
      return item;
   endfunction

   task automatic offer(input req_type item);
      if (!calm && $urandom_range(0, 99) < 2) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_payload <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(item);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (!sb.drained()) @(negedge clock);
   endtask

   task automatic configure(input logic [15:0] spr, input logic [15:0] rpm, input bit spare);
      logic [CSR_INDEX_BITS-1:0] spare_index;
      logic [15:0]               spare_data;
      csr_we <= 1'b1;
      csr_index <= CSR_STEPS_PER_REV;
      csr_wdata <= spr;
      sb.write_reg(CSR_STEPS_PER_REV, spr);
      @(negedge clock);
      csr_index <= CSR_SPEED_RPM;
      csr_wdata <= rpm;
      sb.write_reg(CSR_SPEED_RPM, rpm);
      @(negedge clock);
      if (spare) begin
         spare_index = $urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO;
         spare_data = 16'($urandom);
         csr_index <= spare_index;
         csr_wdata <= spare_data;
         sb.write_reg(spare_index, spare_data);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [15:0] spr;
      logic [15:0] rpm;
      sb = new();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // coils off before any step, zero move, moves replacing moves
      offer(make_item(CMD_TICK, 24'sd0));
      offer(make_item(CMD_MOVE, 24'sd0));
      offer(make_item(CMD_MOVE, 24'sd3));
      repeat (5) offer(make_item(CMD_TICK, -24'sd1));
      offer(make_item(CMD_MOVE, -24'sd2));
      repeat (5) offer(make_item(CMD_TICK, 24'sd0));
      offer(make_item(CMD_MOVE, {1'b1, {(COUNT_BITS-1){1'b0}}}));
      offer(make_item(CMD_MOVE, 24'sd0));
      offer(make_item(CMD_MOVE, {1'b0, {(COUNT_BITS-1){1'b1}}}));
      offer(make_item(CMD_MOVE, 24'sd0));

      // zero interval, then position left beyond a shrunken revolution, then zero settings with a spare csr write
      wait_drained();
      configure(16'd1, 16'hFFFF, 1'b0);
      offer(make_item(CMD_MOVE, 24'sd1));
      wait_drained();
      configure(16'd200, 16'hFFFF, 1'b0);
      offer(make_item(CMD_MOVE, -24'sd1));
      wait_drained();
      configure(16'd100, 16'hFFFF, 1'b0);
      offer(make_item(CMD_MOVE, 24'sd1));
      wait_drained();
      configure(16'd200, 16'hFFFF, 1'b0);
      offer(make_item(CMD_MOVE, -24'sd1));
      wait_drained();
      configure(16'd50, 16'hFFFF, 1'b0);
      offer(make_item(CMD_MOVE, -24'sd1));
      wait_drained();
      configure(16'd0, 16'd0, 1'b1);
      offer(make_item(CMD_MOVE, 24'sd2));
      offer(make_item(CMD_TICK, 24'sd0));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         case (p)
            0: begin spr = RESET_STEPS_PER_REV; rpm = RESET_SPEED_RPM; end
            2: begin spr = 16'hFFFF; rpm = 16'hFFFF; end
            3: begin spr = 16'd1; rpm = 16'd1; end
            4: begin spr = 16'd4; rpm = 16'd1000; end
            5: begin spr = 16'd3; rpm = 16'd2000; end
            default: begin
               spr = 16'($urandom_range(1, 300));
               rpm = 16'($urandom_range(50, 1500));
            end
         endcase
         configure(spr, rpm, p[0]);
         calm = (p == 4);
         if (p == 2) begin
            hold_req = 1'b1;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 5 && k == PHASE_ITEMS / 2) begin
               wait_drained();
            end
            offer(random_item());
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.drained()) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/stpr_pkg.sv
rtl/stpr_interval_div.sv
rtl/stpr_step_core.sv
rtl/four_wire_stepper_sequencer_unit.sv
bench/tb_top.sv
